// ===== src/mps_pkg.sv =====
// Shared types, constants and helpers for the motor plant step block.
package mps_pkg;

  localparam int unsigned DEF_CHANNELS  = 4;
  localparam int unsigned DEF_FRAC_BITS = 16;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POS_PER_VEL  = 3'd0,
    CFG_VEL_DECAY    = 3'd1,
    CFG_POS_PER_VOLT = 3'd2,
    CFG_VEL_PER_VOLT = 3'd3,
    CFG_STATIC_FRIC  = 3'd4
  } mps_cfg_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_MUL_WAIT,
    ST_DIV,
    ST_DIV_WAIT,
    ST_SHARE,
    ST_NET,
    ST_WRITE
  } mps_state_e;

  // multiply-add steps, in the order the sequencer runs them
  typedef enum logic [2:0] {
    OP_AXPOS = 3'd0,
    OP_AXVEL = 3'd1,
    OP_VFRIC = 3'd2,
    OP_NPOS  = 3'd3,
    OP_NVEL  = 3'd4
  } mps_op_e;

  localparam logic signed [65:0] SAT_HI = 66'sh0_7FFF_FFFF;
  localparam logic signed [65:0] SAT_LO = -66'sh0_8000_0000;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > SAT_HI) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < SAT_LO) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ===== src/mps_if.sv =====
// Valid/ready channel interfaces for the input word and the result word.
interface mps_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         channel;
  logic signed [31:0] applied_volts;

  modport source(output valid, output channel, output applied_volts, input ready);
  modport sink(input valid, input channel, input applied_volts, output ready);
endinterface

interface mps_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         channel_out;
  logic signed [31:0] new_position;
  logic signed [31:0] new_velocity;

  modport source(output valid, output channel_out, output new_position,
                 output new_velocity, input ready);
  modport sink(input valid, input channel_out, input new_position,
               input new_velocity, output ready);
endinterface

// ===== src/mps_ram.sv =====
// Generic single-port-write, registered-read RAM.
module mps_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 4,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/mps_mac.sv =====
// Shared multiply, floor-shift, add and saturate unit; product and result are registered.
module mps_mac #(
  parameter int unsigned FRAC_BITS = mps_pkg::DEF_FRAC_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               go_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  input  logic signed [31:0] c_i,
  output logic signed [31:0] res_o,
  output logic               done_o
);
  import mps_pkg::*;

  logic signed [63:0] prod_d, prod_q;
  logic signed [31:0] c_q;
  logic signed [65:0] sum;
  logic signed [31:0] res_q;
  logic               v1_q, done_q;

  assign prod_d = 64'(a_i) * 64'(b_i);

  // arithmetic shift gives the round-toward-minus-infinity product
  assign sum = 66'(prod_q >>> FRAC_BITS) + 66'(c_q);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    c_q    <= c_i;
    res_q  <= sat32(sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      done_q <= 1'b0;
    end else begin
      v1_q   <= go_i;
      done_q <= v1_q;
    end
  end

  assign res_o  = res_q;
  assign done_o = done_q;

endmodule

// ===== src/mps_div.sv =====
// Serial restoring divider: sat32((num << FRAC_BITS) / -den), one bit per cycle.
module mps_div #(
  parameter int unsigned FRAC_BITS = mps_pkg::DEF_FRAC_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] num_i,
  input  logic signed [31:0] den_i,
  output logic signed [31:0] q_o,
  output logic               done_o
);
  import mps_pkg::*;

  localparam int unsigned NW = 32 + FRAC_BITS;
  localparam int unsigned CW = $clog2(NW + 1);
  localparam logic [NW-1:0] MAG_NEG = NW'(64'h8000_0000);
  localparam logic [NW-1:0] MAG_POS = NW'(64'h7FFF_FFFF);

  logic          busy_q, done_q, zero_q, neg_q;
  logic [CW-1:0] cnt_q;
  logic [31:0]   rem_q, dmag_q;
  logic [NW-1:0] nq_q;

  logic [31:0]   nmag, dmag;
  logic [32:0]   trial;
  logic          ge;
  logic [32:0]   diff;

  assign nmag  = num_i[31] ? (~num_i + 32'd1) : num_i;
  assign dmag  = den_i[31] ? (~den_i + 32'd1) : den_i;
  assign trial = {rem_q, nq_q[NW-1]};
  assign ge    = trial >= {1'b0, dmag_q};
  assign diff  = trial - {1'b0, dmag_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      zero_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        zero_q <= (den_i == 32'sd0);
        busy_q <= (den_i != 32'sd0);
        done_q <= (den_i == 32'sd0);
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(NW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      nq_q   <= {nmag, {FRAC_BITS{1'b0}}};
      dmag_q <= dmag;
      // divisor is -den: negative quotient when signs of num and -den differ
      neg_q  <= num_i[31] ^ ~den_i[31];
    end else if (busy_q) begin
      rem_q <= ge ? diff[31:0] : trial[31:0];
      nq_q  <= {nq_q[NW-2:0], ge};
    end
  end

  always_comb begin
    if (zero_q) begin
      q_o = '0;
    end else if (neg_q) begin
      q_o = (nq_q > MAG_NEG) ? 32'sh8000_0000 : (~nq_q[31:0] + 32'd1);
    end else begin
      q_o = (nq_q > MAG_POS) ? 32'sh7FFF_FFFF : nq_q[31:0];
    end
  end

  assign done_o = done_q;

endmodule

// ===== src/motor_plant_step_with_static_friction.sv =====
// Multi-channel motor plant step with static friction; sequencer top level.
// Each word takes five passes through the shared MAC and two bit-serial divides.
// A zero vel_per_volt_coef makes each divide give zero without the serial steps;
// a channel at or above CHANNELS skips both and gives zero position and velocity.
// A new word is taken only in idle, so it may be taken while the last result waits.
// Reset: async active low; clears all channel states to zero and loads register defaults.
module motor_plant_step_with_static_friction #(
  parameter int unsigned CHANNELS  = mps_pkg::DEF_CHANNELS,
  parameter int unsigned FRAC_BITS = mps_pkg::DEF_FRAC_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  mps_in_if.sink                           in_i,
  mps_out_if.source                        out_o,
  input  logic                             cfg_we_i,
  input  logic [mps_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [mps_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import mps_pkg::*;

  localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic signed [31:0] Q_ONE = 32'sh1 << FRAC_BITS;

  mps_state_e state_q, state_d;
  mps_op_e    op_q, op_next;

  // registers
  logic signed [31:0] a01_q, a11_q, b0_q, b1_q;
  logic [30:0]        ks_q;
  logic [CHANNELS-1:0] vld_q;
  logic               div2_q, out_vld_q, inr_q, rd_vld_q;
  logic [1:0]         ch_q, out_ch_q;
  logic signed [31:0] uin_q, pos_q, vel_q, axpos_q, axvel_q, vfric_q;
  logic signed [31:0] sys_q, stop_q, share_q, u_q, npos_q, nvel_q;
  logic signed [31:0] out_pos_q, out_vel_q;

  // control
  logic mac_go, mac_done, div_start, div_done, out_free, out_load, ram_we;
  logic signed [31:0] mac_a, mac_b, mac_c, mac_res, div_num, div_q;
  logic [63:0]        ram_rdata;
  logic               in_acc, in_range;

  assign in_acc   = in_i.valid & in_i.ready;
  assign in_range = 32'(in_i.channel) < CHANNELS;

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:     if (in_i.valid) state_d = ST_READ;
      ST_READ:     state_d = inr_q ? ST_MUL : ST_WRITE;
      ST_MUL:      state_d = ST_MUL_WAIT;
      ST_MUL_WAIT: begin
        if (mac_done) begin
          unique case (op_q)
            OP_NVEL:           state_d = ST_WRITE;
            OP_AXVEL, OP_VFRIC: state_d = ST_DIV;
            default:           state_d = ST_MUL;
          endcase
        end
      end
      ST_DIV:      state_d = ST_DIV_WAIT;
      ST_DIV_WAIT: if (div_done) state_d = div2_q ? ST_SHARE : ST_MUL;
      ST_SHARE:    state_d = ST_NET;
      ST_NET:      state_d = ST_MUL;
      ST_WRITE:    if (out_free) state_d = ST_IDLE;
      default:     state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_i.ready = (state_q == ST_IDLE);
    mac_go     = (state_q == ST_MUL);
    div_start  = (state_q == ST_DIV);
    out_free   = !out_vld_q || out_o.ready;
    out_load   = (state_q == ST_WRITE) && out_free;
    ram_we     = out_load && inr_q;
  end

  always_comb begin
    unique case (op_q)
      OP_AXPOS: op_next = OP_AXVEL;
      OP_AXVEL: op_next = OP_VFRIC;
      OP_VFRIC: op_next = OP_NPOS;
      OP_NPOS:  op_next = OP_NVEL;
      default:  op_next = OP_AXPOS;
    endcase
  end

  // ---------------- MAC operand select ----------------
  always_comb begin
    unique case (op_q)
      OP_AXVEL: begin mac_a = a11_q; mac_b = vel_q; mac_c = '0;      end
      OP_VFRIC: begin mac_a = b1_q;  mac_b = sys_q; mac_c = axvel_q; end
      OP_NPOS:  begin mac_a = b0_q;  mac_b = u_q;   mac_c = axpos_q; end
      OP_NVEL:  begin mac_a = b1_q;  mac_b = u_q;   mac_c = axvel_q; end
      default:  begin mac_a = a01_q; mac_b = vel_q; mac_c = pos_q;   end
    endcase
  end

  assign div_num = div2_q ? vfric_q : axvel_q;

  mps_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .go_i   (mac_go),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .c_i    (mac_c),
    .res_o  (mac_res),
    .done_o (mac_done)
  );

  mps_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (b1_q),
    .q_o     (div_q),
    .done_o  (div_done)
  );

  mps_ram #(.WIDTH(64), .DEPTH(CHANNELS)) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(ch_q)),
    .wdata_i ({npos_q, nvel_q}),
    .raddr_i (AW'(in_i.channel)),
    .rdata_o (ram_rdata)
  );

  // ---------------- friction logic ----------------
  logic signed [31:0] ks_s, sys_clamp;
  logic signed [33:0] uin_x, stop_x, sys_x, ks_x, abs_sys, lim1, dif, lim2, lim, mag;
  logic               stuck, slip;
  logic signed [31:0] share_d;
  logic signed [65:0] net;

  assign ks_s = signed'({1'b0, ks_q});

  always_comb begin
    if (div_q < -ks_s) begin
      sys_clamp = -ks_s;
    end else if (div_q > ks_s) begin
      sys_clamp = ks_s;
    end else begin
      sys_clamp = div_q;
    end
  end

  always_comb begin
    uin_x   = 34'(uin_q);
    stop_x  = 34'(stop_q);
    sys_x   = 34'(sys_q);
    ks_x    = signed'({3'b000, ks_q});
    abs_sys = (sys_x < 0) ? -sys_x : sys_x;
    lim1    = (uin_x < 0) ? -uin_x : uin_x;
    dif     = uin_x - stop_x;
    lim2    = (dif < 0) ? -dif : dif;
    stuck   = abs_sys < ks_x;
    // applied voltage past the stop voltage, on the side away from zero
    slip    = ((stop_x > 0) && (uin_x > stop_x)) || ((stop_x < 0) && (uin_x < stop_x));
    lim     = stuck ? lim1 : lim2;
    mag     = (ks_x < lim) ? ks_x : lim;
    if (!(stuck || slip) || (uin_q == 32'sd0)) begin
      share_d = '0;
    end else if (uin_q > 32'sd0) begin
      share_d = -(32'(mag));
    end else begin
      share_d = 32'(mag);
    end
  end

  assign net = 66'(uin_q) + 66'(sys_q) + 66'(share_q);

  // ---------------- control registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      op_q      <= OP_AXPOS;
      div2_q    <= 1'b0;
      out_vld_q <= 1'b0;
      vld_q     <= '0;
      a01_q     <= '0;
      a11_q     <= Q_ONE;
      b0_q      <= '0;
      b1_q      <= Q_ONE;
      ks_q      <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_READ) begin
        op_q   <= OP_AXPOS;
        div2_q <= 1'b0;
      end
      if ((state_q == ST_MUL_WAIT) && mac_done) begin
        op_q <= op_next;
      end
      if ((state_q == ST_DIV_WAIT) && div_done) begin
        div2_q <= 1'b1;
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
      if (ram_we) begin
        vld_q[AW'(ch_q)] <= 1'b1;
      end
      if (cfg_we_i) begin
        case (mps_cfg_e'(cfg_idx_i))
          CFG_POS_PER_VEL:  a01_q <= cfg_data_i;
          CFG_VEL_DECAY:    a11_q <= cfg_data_i;
          CFG_POS_PER_VOLT: b0_q  <= cfg_data_i;
          CFG_VEL_PER_VOLT: b1_q  <= cfg_data_i;
          CFG_STATIC_FRIC:  ks_q  <= cfg_data_i[30:0];
          default: ;
        endcase
      end
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      ch_q     <= in_i.channel;
      uin_q    <= in_i.applied_volts;
      inr_q    <= in_range;
      rd_vld_q <= vld_q[AW'(in_i.channel)] & in_range;
    end
    if (state_q == ST_READ) begin
      pos_q <= rd_vld_q ? ram_rdata[63:32] : '0;
      vel_q <= rd_vld_q ? ram_rdata[31:0]  : '0;
    end
    if ((state_q == ST_MUL_WAIT) && mac_done) begin
      unique case (op_q)
        OP_AXVEL: axvel_q <= mac_res;
        OP_VFRIC: vfric_q <= mac_res;
        OP_NPOS:  npos_q  <= mac_res;
        OP_NVEL:  nvel_q  <= mac_res;
        default:  axpos_q <= mac_res;
      endcase
    end
    if ((state_q == ST_DIV_WAIT) && div_done) begin
      if (div2_q) begin
        stop_q <= div_q;
      end else begin
        sys_q <= sys_clamp;
      end
    end
    if (state_q == ST_SHARE) begin
      share_q <= share_d;
    end
    if (state_q == ST_NET) begin
      u_q <= sat32(net);
    end
    if (out_load) begin
      out_ch_q  <= ch_q;
      out_pos_q <= inr_q ? npos_q : '0;
      out_vel_q <= inr_q ? nvel_q : '0;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.channel_out  = out_ch_q;
  assign out_o.new_position = out_pos_q;
  assign out_o.new_velocity = out_vel_q;

`ifndef ASSERT_OFF
  a_mac_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |-> (state_q == ST_MUL_WAIT))
    else $error("MAC completion outside its wait state");

  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV_WAIT))
    else $error("divider completion outside its wait state");

  a_out_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_o.valid && (out_o.channel_out == $past(ch_q))))
    else $error("result word not presented after load");
`endif

endmodule

// ===== verif/tb_motor_plant_step_with_static_friction.sv =====
// Testbench for the multi-channel motor plant step with static friction.
module tb_motor_plant_step_with_static_friction;
  timeunit 1ns;
  timeprecision 1ps;

  import mps_pkg::*;

  localparam int unsigned FRAC          = DEF_FRAC_BITS;
  localparam int          PLANT_LATENCY = 2 * (32 + FRAC) + 24;
  localparam int          STALL_LIMIT   = 3000;
  localparam int          RX_HOLD       = 500;
  localparam longint      S32_HI        = 64'sd2147483647;
  localparam longint      S32_LO        = -64'sd2147483648;

  typedef struct packed {
    logic [1:0]         chan;
    logic signed [31:0] pos;
    logic signed [31:0] vel;
  } plant_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  mps_in_if  in_if ();
  mps_out_if out_if ();

  motor_plant_step_with_static_friction u_top (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .in_i      (in_if),
    .out_o     (out_if),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // plant copy: coefficients and per-channel state
  longint pv_gain    = 0;
  longint decay_gain = 64'sd65536;
  longint pu_gain    = 0;
  longint vu_gain    = 64'sd65536;
  longint fric_volts = 0;
  longint plant_pos[DEF_CHANNELS];
  longint plant_vel[DEF_CHANNELS];

  plant_word_t expected_q[$];
  int words_sent   = 0;
  int results_seen = 0;
  int mismatches   = 0;
  bit tx_quiet     = 1'b0;
  bit rx_quiet     = 1'b0;
  int rx_hold      = 0;

  function automatic longint clip32(input longint v);
    if (v > S32_HI) return S32_HI;
    if (v < S32_LO) return S32_LO;
    return v;
  endfunction

  function automatic longint bound(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic longint signum(input longint v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // floor of the Q product
  function automatic longint fx_mul(input longint a, input longint b);
    return (a * b) >>> FRAC;
  endfunction

  // voltage that would bring vel to a stop; zero gain means no stop voltage
  function automatic longint brake_volts(input longint vel, input longint gain);
    if (gain == 0) return 0;
    return clip32((vel <<< FRAC) / (-gain));
  endfunction

  function automatic plant_word_t advance_plant(input logic [1:0] ch,
                                                input logic signed [31:0] volts);
    longint u_in, pos, vel, ax_pos, ax_vel, stop, sys_share, in_share, g, h, lim, u;
    plant_word_t r;
    u_in = longint'(volts);
    pos = plant_pos[ch];
    vel = plant_vel[ch];
    ax_pos = clip32(pos + fx_mul(pv_gain, vel));
    ax_vel = clip32(fx_mul(decay_gain, vel));
    stop = brake_volts(ax_vel, vu_gain);
    sys_share = bound(stop, -fric_volts, fric_volts);
    stop = brake_volts(clip32(ax_vel + fx_mul(vu_gain, sys_share)), vu_gain);
    g = signum(stop);
    h = signum(u_in);
    in_share = 0;
    if (magnitude(sys_share) < fric_volts) begin
      lim = magnitude(u_in);
      in_share = -bound(fric_volts * h, -lim, lim);
    end else if (u_in * g > stop * g) begin
      lim = magnitude(u_in - stop);
      in_share = -bound(fric_volts * h, -lim, lim);
    end
    u = clip32(u_in + sys_share + in_share);
    pos = clip32(ax_pos + fx_mul(pu_gain, u));
    vel = clip32(ax_vel + fx_mul(vu_gain, u));
    plant_pos[ch] = pos;
    plant_vel[ch] = vel;
    r.chan = ch;
    r.pos = pos[31:0];
    r.vel = vel[31:0];
    return r;
  endfunction

  function automatic int draw_wait(input bit quiet);
    if (quiet) return 0;
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
  endfunction

  // mostly within +/-12 V, sometimes any 32-bit value
  function automatic logic signed [31:0] random_volts();
    if ($urandom_range(0, 99) < 85) return $signed($urandom_range(0, 1572864)) - 786432;
    return $urandom;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic send_word(input logic [1:0] ch, input logic signed [31:0] volts);
    int gap;
    gap = draw_wait(tx_quiet);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.channel <= ch;
    in_if.applied_volts <= volts;
    words_sent++;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // stop offering words and wait for every outstanding result
  task automatic settle();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (results_seen != words_sent);
  endtask

  task automatic put_reg(input mps_cfg_e idx, input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic write_coefs(input logic signed [31:0] pvel, input logic signed [31:0] decay,
                             input logic signed [31:0] pvolt, input logic signed [31:0] vvolt,
                             input logic [30:0] kfr);
    put_reg(CFG_POS_PER_VEL, pvel);
    put_reg(CFG_VEL_DECAY, decay);
    put_reg(CFG_POS_PER_VOLT, pvolt);
    put_reg(CFG_VEL_PER_VOLT, vvolt);
    put_reg(CFG_STATIC_FRIC, {1'b0, kfr});
    cfg_we <= 1'b0;
    pv_gain = longint'(pvel);
    decay_gain = longint'(decay);
    pu_gain = longint'(pvolt);
    vu_gain = longint'(vvolt);
    fric_volts = longint'(kfr);
  endtask

  // result checker and expectation builder
  always @(posedge clk) begin
    plant_word_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("unexpected word ch=%0d", out_if.channel_out));
      end else begin
        want = expected_q.pop_front();
        if (out_if.channel_out !== want.chan)
          report_mismatch($sformatf("channel got %0d want %0d", out_if.channel_out, want.chan));
        if (out_if.new_position !== want.pos)
          report_mismatch($sformatf("ch%0d position got %h want %h",
                                    want.chan, out_if.new_position, want.pos));
        if (out_if.new_velocity !== want.vel)
          report_mismatch($sformatf("ch%0d velocity got %h want %h",
                                    want.chan, out_if.new_velocity, want.vel));
      end
    end
    if (rst_n && in_if.valid && in_if.ready)
      expected_q.push_back(advance_plant(in_if.channel, in_if.applied_volts));
  end

  // result receiver with random stalls and a long hold on request
  initial begin
    int stall;
    out_if.ready = 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_hold > 0) begin
        out_if.ready <= 1'b0;
        repeat (rx_hold) @(posedge clk);
        rx_hold = 0;
      end
      stall = draw_wait(rx_quiet);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!out_if.valid);
    end
  end

  initial begin
    int idle_run;
    idle_run = 0;
    while (idle_run < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_run = 0;
      else idle_run++;
    end
    $display("Some tests failed");
    $finish;
  end

  // reset coefficients; paired inputs per channel that roughly cancel leave velocities near zero
  task automatic test_reset_defaults();
    send_word(2'd0, 32'sh7FFF_FFFF);
    send_word(2'd0, 32'sh8000_0000);
    send_word(2'd1, 32'sd1);
    send_word(2'd1, -32'sd1);
    send_word(2'd2, 32'sd0);
    send_word(2'd2, -32'sd1);
    send_word(2'd3, 32'sh8000_0000);
    send_word(2'd3, 32'sh7FFF_FFFF);
    settle();
  endtask

  // kS = 1 V: stuck below kS, breakaway, reversal, coasting
  task automatic test_static_friction();
    write_coefs(32'sd655, 32'sd65536, 32'sd256, 32'sd32768, 31'h10000);
    send_word(2'd1, 32'sh8000);
    send_word(2'd1, -32'sh8000);
    send_word(2'd1, 32'sh10000);
    send_word(2'd1, 32'sh30000);
    send_word(2'd1, 32'sh30000);
    send_word(2'd1, -32'sh30000);
    send_word(2'd1, 32'sd0);
    send_word(2'd1, -32'sh50000);
    settle();
  endtask

  task automatic test_zero_velocity_gain();
    write_coefs(32'sd3277, 32'sd60000, 32'sd1000, 32'sd0, 31'h20000);
    send_word(2'd2, 32'sd0);
    send_word(2'd2, 32'sh40000);
    send_word(2'd2, -32'sh8000);
    send_word(2'd3, 32'sh8000_0000);
    settle();
  endtask

  task automatic test_extreme_coefs();
    write_coefs(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF, 31'h7FFF_FFFF);
    send_word(2'd0, 32'sh7FFF_FFFF);
    send_word(2'd1, 32'sh8000_0000);
    send_word(2'd0, 32'sd0);
    settle();
    write_coefs(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 31'h0);
    send_word(2'd2, 32'sh8000_0000);
    send_word(2'd3, 32'sh7FFF_FFFF);
    send_word(2'd2, -32'sd1);
    settle();
  endtask

  task automatic test_random_sweep();
    logic signed [31:0] vv;
    for (int phase = 0; phase < 8; phase++) begin
      if (phase % 4 == 3) begin
        write_coefs($urandom, $urandom, $urandom, $urandom,
                    31'($urandom_range(0, 32'h7FFF_FFFF)));
      end else begin
        vv = $urandom_range(1, 131072);
        if ($urandom_range(0, 1)) vv = -vv;
        write_coefs($urandom_range(0, 6554), $urandom_range(45875, 65536),
                    $urandom_range(0, 3277), vv, 31'($urandom_range(0, 262144)));
      end
      tx_quiet = (phase == 2);
      rx_quiet = (phase == 5);
      for (int n = 0; n < 60; n++) send_word(2'($urandom_range(0, 3)), random_volts());
      settle();
    end
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    rx_hold = RX_HOLD;
    tx_quiet = 1'b1;
    for (int n = 0; n < 20; n++) send_word(2'($urandom_range(0, 3)), random_volts());
    tx_quiet = 1'b0;
    settle();
  endtask

  task automatic test_back_to_back();
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    for (int n = 0; n < 60; n++) send_word(2'($urandom_range(0, 3)), random_volts());
    settle();
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  initial begin
    foreach (plant_pos[i]) begin
      plant_pos[i] = 0;
      plant_vel[i] = 0;
    end
    in_if.valid = 1'b0;
    in_if.channel = '0;
    in_if.applied_volts = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_static_friction();
    test_zero_velocity_gain();
    test_extreme_coefs();
    test_random_sweep();
    test_backpressure();
    test_back_to_back();

    repeat (2 * PLANT_LATENCY) @(posedge clk);
    if (expected_q.size() != 0)
      report_mismatch($sformatf("%0d expected words never came", expected_q.size()));
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
